// ----- rtl/wsts_pkg.sv -----
package wsts_pkg;

    localparam int LEVELS_DEF        = 10;
    localparam int PRIORITY_BITS_DEF = 32;
    localparam int MAX_LEVELS        = 16;
    localparam int QUERY_BITS        = 42;
    localparam int INDEX_BITS        = 10;

    typedef enum logic
    {
        OP_SET   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_PEEK,
        ST_LAUNCH,
        ST_WAIT
    } state_t;

    typedef struct packed
    {
        logic                  en;
        logic [MAX_LEVELS-1:0] addr;
    } clr_t;

endpackage

// ----- rtl/weighted_sum_tree_sampler_core.sv -----
// Sum tree over 2^LEVELS leaves, one cell per tree level, each cell holding the node sums of
// its level in a local memory. After reset a clearing pass zeroes every level with busy
// high. An item is taken when start is high and busy is low; the token then walks the cell
// chain, each cell doing a memory read, then add-and-write or compare-and-subtract. An
// update first reads the old leaf value before its token is launched. The result is shown
// with strobe high for one cycle and cannot be held off; a new item may be started in that
// same cycle.
module weighted_sum_tree_sampler_core
    import wsts_pkg::*;
#(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [INDEX_BITS-1:0] leaf_index,
    input  logic [31:0]           priority_req,
    input  logic [QUERY_BITS-1:0] query_target,
    output logic                  strobe,
    output logic                  result_kind,
    output logic [INDEX_BITS-1:0] found_index
);

    localparam int SUM_BITS = PRIORITY_BITS + LEVELS;
    localparam int VAL_BITS = (SUM_BITS > QUERY_BITS) ? SUM_BITS : QUERY_BITS;

    state_t                state_reg, state_next;
    logic [LEVELS:0]       clr_cnt_reg, clr_cnt_next;
    op_t                   op_reg;
    logic [LEVELS-1:0]     idx_reg;
    logic [VAL_BITS-1:0]   val_reg;
    logic                  strobe_reg, strobe_next;
    logic                  kind_reg, kind_next;
    logic [INDEX_BITS-1:0] found_reg, found_next;
    logic                  accept;
    logic [31:0]           prio_cut;
    logic [SUM_BITS-1:0]   delta;
    clr_t                  clr;

    logic [LEVELS:0]       tv;
    op_t                   top [LEVELS+1];
    logic [LEVELS-1:0]     tidx [LEVELS+1];
    logic [VAL_BITS-1:0]   tval [LEVELS+1];
    logic [SUM_BITS-1:0]   rdv [LEVELS];

    assign accept   = start && !busy;
    assign prio_cut = priority_req & 32'(({PRIORITY_BITS{1'b1}}));
    assign delta    = SUM_BITS'(val_reg) - rdv[LEVELS-1];
    assign clr.en   = state_reg == ST_CLEAR;
    assign clr.addr = MAX_LEVELS'(clr_cnt_reg[LEVELS-1:0]);

    assign tv[0]   = state_reg == ST_LAUNCH;
    assign top[0]  = op_reg;
    assign tidx[0] = (op_reg == OP_SET) ? idx_reg : '0;
    assign tval[0] = (op_reg == OP_SET) ? VAL_BITS'(delta) : val_reg;

    for (genvar k = 0; k < LEVELS; k++)
    begin : g_cell
        wsts_cell #(
            .LEVELS   (LEVELS),
            .LVL      (k + 1),
            .SUM_BITS (SUM_BITS),
            .VAL_BITS (VAL_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clr       (clr),
            .peek_en   ((k == LEVELS - 1) && (state_reg == ST_PEEK)),
            .peek_idx  (idx_reg),
            .rd_data   (rdv[k]),
            .in_valid  (tv[k]),
            .in_op     (top[k]),
            .in_idx    (tidx[k]),
            .in_val    (tval[k]),
            .out_valid (tv[k+1]),
            .out_op    (top[k+1]),
            .out_idx   (tidx[k+1]),
            .out_val   (tval[k+1])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        strobe_next  = 1'b0;
        kind_next    = kind_reg;
        found_next   = found_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg[LEVELS-1:0] == {LEVELS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (op_t'(action) == OP_SET) ? ST_PEEK : ST_LAUNCH;
                end
            end
            ST_PEEK:
            begin
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (tv[LEVELS])
                begin
                    state_next  = ST_IDLE;
                    strobe_next = 1'b1;
                    kind_next   = top[LEVELS] == OP_QUERY;
                    found_next  = (top[LEVELS] == OP_QUERY) ?
                                  INDEX_BITS'(tidx[LEVELS]) : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        found_reg <= found_next;
        if (accept)
        begin
            op_reg  <= op_t'(action);
            idx_reg <= LEVELS'(leaf_index);
            val_reg <= (op_t'(action) == OP_SET) ? VAL_BITS'(prio_cut) : VAL_BITS'(query_target);
        end
    end

    assign busy        = state_reg != ST_IDLE;
    assign strobe      = strobe_reg;
    assign result_kind = kind_reg;
    assign found_index = found_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tv))
        else $error("more than one token in the cell chain");
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(tv[LEVELS]))
        else $error("result strobe without a token leaving the chain");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after a transfer");
    a_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result_kind |-> found_index == '0)
        else $error("update result carries a nonzero index");

endmodule

// ----- rtl/wsts_cell.sv -----
module wsts_cell
    import wsts_pkg::*;
#(
    parameter int LEVELS   = LEVELS_DEF,
    parameter int LVL      = 1,
    parameter int SUM_BITS = PRIORITY_BITS_DEF + LEVELS_DEF,
    parameter int VAL_BITS = QUERY_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  clr_t                clr,
    input  logic                peek_en,
    input  logic [LEVELS-1:0]   peek_idx,
    output logic [SUM_BITS-1:0] rd_data,
    input  logic                in_valid,
    input  op_t                 in_op,
    input  logic [LEVELS-1:0]   in_idx,
    input  logic [VAL_BITS-1:0] in_val,
    output logic                out_valid,
    output op_t                 out_op,
    output logic [LEVELS-1:0]   out_idx,
    output logic [VAL_BITS-1:0] out_val
);

    logic [SUM_BITS-1:0] mem [2**LVL];
    logic [SUM_BITS-1:0] rd_reg;
    logic                stg_valid_reg;
    op_t                 stg_op_reg;
    logic [LEVELS-1:0]   stg_idx_reg;
    logic [VAL_BITS-1:0] stg_val_reg;
    logic                out_valid_reg;
    op_t                 out_op_reg;
    logic [LEVELS-1:0]   out_idx_reg;
    logic [VAL_BITS-1:0] out_val_reg;
    logic [LEVELS-1:0]   out_idx_next;
    logic [VAL_BITS-1:0] out_val_next;
    logic [LVL-1:0]      rd_addr;
    logic [LVL-1:0]      stg_addr;
    logic [VAL_BITS-1:0] sum_ext;
    logic                go_right;
    logic [LEVELS-1:0]   bit_mask;

    assign rd_addr  = in_valid ? in_idx[LEVELS-1 -: LVL] : peek_idx[LEVELS-1 -: LVL];
    assign stg_addr = stg_idx_reg[LEVELS-1 -: LVL];
    assign sum_ext  = VAL_BITS'(rd_reg);
    assign go_right = stg_val_reg >= sum_ext;
    assign bit_mask = LEVELS'(1) << (LEVELS - LVL);

    always_ff @(posedge clk)
    begin
        if (in_valid || peek_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (clr.en)
        begin
            mem[clr.addr[LVL-1:0]] <= '0;
        end
        else if (stg_valid_reg && stg_op_reg == OP_SET)
        begin
            mem[stg_addr] <= SUM_BITS'(rd_reg + stg_val_reg[SUM_BITS-1:0]);
        end
    end

    always_comb
    begin
        out_idx_next = stg_idx_reg;
        out_val_next = stg_val_reg;
        if (stg_op_reg == OP_QUERY && go_right)
        begin
            out_idx_next = stg_idx_reg | bit_mask;
            out_val_next = stg_val_reg - sum_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= in_valid;
            out_valid_reg <= stg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stg_op_reg  <= in_op;
            stg_idx_reg <= in_idx;
            stg_val_reg <= in_val;
        end
        if (stg_valid_reg)
        begin
            out_op_reg  <= stg_op_reg;
            out_idx_reg <= out_idx_next;
            out_val_reg <= out_val_next;
        end
    end

    assign rd_data   = rd_reg;
    assign out_valid = out_valid_reg;
    assign out_op    = out_op_reg;
    assign out_idx   = out_idx_reg;
    assign out_val   = out_val_reg;

endmodule
